/* hdl/dst_pkg.sv */
`default_nettype none
package dst_pkg;

   localparam int DST_CORNER_COUNT = 4;
   localparam int DST_COORD_BITS   = 16;

   localparam logic [31:0] DST_SEQ_HALF = 32'h7FFF_FFFF;
   localparam int          DST_RSP_W    = 160;

   localparam logic [1:0] MODE_ABSENT = 2'd0;
   localparam logic [1:0] MODE_TRACK  = 2'd1;
   localparam logic [1:0] MODE_LOCKED = 2'd2;

   localparam logic [3:0] RSN_WAIT_REMOVAL = 4'd0;
   localparam logic [3:0] RSN_ACQUIRED     = 4'd1;
   localparam logic [3:0] RSN_DUPLICATE    = 4'd2;
   localparam logic [3:0] RSN_MOVED        = 4'd3;
   localparam logic [3:0] RSN_STABLE       = 4'd4;
   localparam logic [3:0] RSN_PRESTABLE    = 4'd5;
   localparam logic [3:0] RSN_PENDING      = 4'd6;
   localparam logic [3:0] RSN_NOT_DETECTED = 4'd7;
   localparam logic [3:0] RSN_REMOVAL_PEND = 4'd8;
   localparam logic [3:0] RSN_REMOVED      = 4'd9;
   localparam logic [3:0] RSN_TIME_ORDER   = 4'd10;
   localparam logic [3:0] RSN_SEQ_ORDER    = 4'd11;

   localparam logic [2:0] CFG_MIN_OBS      = 3'd0;
   localparam logic [2:0] CFG_MIN_SPAN     = 3'd1;
   localparam logic [2:0] CFG_MIN_IOU      = 3'd2;
   localparam logic [2:0] CFG_MAX_SHIFT    = 3'd3;
   localparam logic [2:0] CFG_MAX_AREA     = 3'd4;
   localparam logic [2:0] CFG_REMOVAL_SPAN = 3'd5;
   localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd6;
   localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd7;

   localparam logic [15:0] RST_MIN_OBS      = 16'd3;
   localparam logic [63:0] RST_MIN_SPAN     = 64'd500000000;
   localparam logic [16:0] RST_MIN_IOU      = 17'd58982;
   localparam logic [17:0] RST_MAX_SHIFT    = 18'd1311;
   localparam logic [31:0] RST_MAX_AREA     = 32'd3277;
   localparam logic [63:0] RST_REMOVAL_SPAN = 64'd500000000;
   localparam logic [11:0] RST_FRAME_WIDTH  = 12'd1920;
   localparam logic [11:0] RST_FRAME_HEIGHT = 12'd1080;

endpackage
`default_nettype wire

/* hdl/dst_div.sv */
`default_nettype none
module dst_div
   import dst_pkg::*;
#(
   parameter int NW = 56,
   parameter int DW = 35
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [NW-1:0]      quot
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [NW-1:0] num_ff;
   logic [DW-1:0] den_ff;
   logic [DW-1:0] rem_ff;
   logic [NW-1:0] quot_ff;

   logic [DW:0]   rem_sh;
   logic          ge;
   logic [DW-1:0] rem_in;

   always_comb begin
      rem_sh = {rem_ff, num_ff[NW-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_in = ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NW);
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            quot_ff <= '0;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            num_ff  <= {num_ff[NW-2:0], 1'b0};
            quot_ff <= {quot_ff[NW-2:0], ge};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

/* hdl/dst_sqrt.sv */
`default_nettype none
module dst_sqrt
   import dst_pkg::*;
#(
   parameter int W = 58
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [W-1:0]   value,
   output logic                done,
   output logic [W/2-1:0]      root
);

   localparam int STEPS = W / 2;
   localparam int CW    = $clog2(STEPS + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [W-1:0]  v_ff;
   logic [W-1:0]  res_ff;
   logic [W-1:0]  rbit_ff;

   logic [W-1:0]  trial;
   logic          ge;

   always_comb begin
      trial = res_ff + rbit_ff;
      ge    = v_ff >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(STEPS);
            v_ff    <= value;
            res_ff  <= '0;
            rbit_ff <= {2'b01, {(W-2){1'b0}}};
         end else if (busy_ff) begin
            if (ge) begin
               v_ff   <= v_ff - trial;
               res_ff <= (res_ff >> 1) + rbit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            rbit_ff <= rbit_ff >> 2;
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[W/2-1:0];

endmodule
`default_nettype wire

/* hdl/document_stability_trigger_core.sv */
// Order errors, missing frames, duplicates and locked frames go from the check straight to the
//   result; a present frame that is compared waits on the shared bit-serial divider doing four
//   divisions, and then on the square root, before its result.
// Throughput: one transaction at a time; the next is taken once the result has been taken.
// Reset: synchronous, active high; clears all tracking state and restores register defaults.
`default_nettype none
module document_stability_trigger_core
   import dst_pkg::*;
#(
   parameter int CORNER_COUNT = DST_CORNER_COUNT,
   parameter int COORD_BITS   = DST_COORD_BITS
) (
   input  wire logic clock,
   input  wire logic reset,

   input  wire logic req_tvalid,
   output logic      req_tready,
   // seq[31:0], time_ns[95:32], then cornerK x,y from K=0 up, zero pad
   input  wire logic [((96 + 2*CORNER_COUNT*COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // operation
   input  wire logic req_tuser,

   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // mode, reason_code, is_prestable, observation_count, stable_span, iou_value,
   // center_shift_value, area_change_value, triggered, rearmed, zero pad
   output logic [DST_RSP_W-1:0] rsp_tdata,

   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   localparam int N     = CORNER_COUNT;
   localparam int CB    = COORD_BITS;
   localparam int BW    = (CB > 16) ? CB : 16;
   localparam int MW    = BW + 1;
   localparam int TW    = 2*CB + $clog2(N) + 1;
   localparam int NW_A  = 2*BW + 24;
   localparam int NW    = (NW_A > TW + 16) ? NW_A : TW + 16;
   localparam int DW_A  = (TW > 2*BW + 1) ? TW : 2*BW + 1;
   localparam int DW    = (DW_A > 24) ? DW_A : 24;
   localparam int SQ_W  = 2*BW + 26;
   localparam int SH_W  = SQ_W / 2;
   localparam int IDXW  = $clog2(N);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_AM, S_AA1, S_AA2, S_ANCH, S_GEO, S_MUL,
      S_DSTART, S_DWAIT, S_SQSTART, S_SQWAIT, S_DEC, S_START, S_OUT
   } state_type;

   // configuration
   logic [15:0] min_obs_ff;
   logic [63:0] min_span_ff;
   logic [16:0] min_iou_ff;
   logic [17:0] max_shift_ff;
   logic [31:0] max_area_ff;
   logic [63:0] removal_ff;
   logic [11:0] fw_ff;
   logic [11:0] fh_ff;

   // tracker state
   state_type   state_ff;
   logic [1:0]  mode_ff;
   logic [BW-1:0] al_ff, at_ff, ar_ff, ab_ff;
   logic [TW-1:0] atwice_ff;
   logic        avalid_ff;
   logic        lsv_ff;
   logic [31:0] lseq_ff;
   logic [63:0] ltime_ff;
   logic [63:0] tstart_ff;
   logic [63:0] mstart_ff;
   logic        mflag_ff;
   logic [15:0] obs_ff;
   logic [16:0] iou_ff;
   logic [17:0] shift_ff;
   logic [31:0] area_ff;
   logic [3:0]  reason_ff;
   logic        trig_ff;
   logic        rearm_ff;

   // transaction payload and working registers
   logic        op_ff;
   logic [31:0] seq_ff;
   logic [63:0] tm_ff;
   logic [CB-1:0] cx_ff [N];
   logic [CB-1:0] cy_ff [N];
   logic [BW-1:0] gl_ff, gt_ff, gr_ff, gb_ff;
   logic [TW-1:0] gtwice_ff;
   logic [TW:0]   acc_ff;
   logic [IDXW-1:0] aidx_ff;
   logic [2*MW-1:0] prod_ff;
   logic [MW-1:0] iw_ff, ih_ff, a0w_ff, a0h_ff, a1w_ff, a1h_ff, dx_ff, dy_ff;
   logic [2*MW-1:0] p_inter_ff, p_a0_ff, p_a1_ff, p_dx2_ff, p_dy2_ff, p_w2_ff, p_h2_ff;
   logic [2:0]  midx_ff;
   logic [1:0]  dsel_ff;
   logic [16:0] iou_q_ff;
   logic [SQ_W-2:0] sx_ff, sy_ff;
   logic [32:0] area_q_ff;
   logic [SH_W-1:0] shift_q_ff;
   logic        div_start_ff;
   logic [NW-1:0] div_num_ff;
   logic [DW-1:0] div_den_ff;
   logic        sq_start_ff;

   logic          div_done;
   logic [NW-1:0] div_quot;
   logic          sq_done;
   logic [SH_W-1:0] sq_root;

   dst_div #(.NW(NW), .DW(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .num(div_num_ff), .den(div_den_ff), .done(div_done), .quot(div_quot)
   );

   dst_sqrt #(.W(SQ_W)) u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start_ff),
      .value(SQ_W'(sx_ff) + SQ_W'(sy_ff)), .done(sq_done), .root(sq_root)
   );

   // effective frame size
   logic [11:0] eff_w, eff_h;
   assign eff_w = (fw_ff == '0) ? 12'd1 : fw_ff;
   assign eff_h = (fh_ff == '0) ? 12'd1 : fh_ff;

   // shared multiplier
   logic [MW-1:0]   mul_a, mul_b;
   logic [2*MW-1:0] mul_p;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_AM: begin
            mul_a = MW'(cx_ff[0]);
            mul_b = MW'(cy_ff[1]);
         end
         S_AA1: begin
            mul_a = MW'(cx_ff[1]);
            mul_b = MW'(cy_ff[0]);
         end
         S_MUL: begin
            unique case (midx_ff)
               3'd0: begin mul_a = iw_ff;  mul_b = ih_ff;  end
               3'd1: begin mul_a = a0w_ff; mul_b = a0h_ff; end
               3'd2: begin mul_a = a1w_ff; mul_b = a1h_ff; end
               3'd3: begin mul_a = dx_ff;  mul_b = dx_ff;  end
               3'd4: begin mul_a = dy_ff;  mul_b = dy_ff;  end
               3'd5: begin mul_a = MW'(eff_w); mul_b = MW'(eff_w); end
               3'd6: begin mul_a = MW'(eff_h); mul_b = MW'(eff_h); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = (2*MW)'(mul_a) * (2*MW)'(mul_b);
   end

   // bounding box of the held corners
   logic [BW-1:0] bl, bt, br, bb;

   always_comb begin
      bl = BW'({eff_w, 4'b0000});
      bt = BW'({eff_h, 4'b0000});
      br = '0;
      bb = '0;
      for (int i = 0; i < N; i++) begin
         if (BW'(cx_ff[i]) < bl) bl = BW'(cx_ff[i]);
         if (BW'(cy_ff[i]) < bt) bt = BW'(cy_ff[i]);
         if (BW'(cx_ff[i]) > br) br = BW'(cx_ff[i]);
         if (BW'(cy_ff[i]) > bb) bb = BW'(cy_ff[i]);
      end
   end

   // overlap and centre geometry
   logic [BW-1:0] lo_x, hi_x, lo_y, hi_y;
   logic [BW:0]   sgx, sax, sgy, say;
   logic [TW-1:0] twice_abs;

   always_comb begin
      lo_x = (al_ff > gl_ff) ? al_ff : gl_ff;
      hi_x = (ar_ff < gr_ff) ? ar_ff : gr_ff;
      lo_y = (at_ff > gt_ff) ? at_ff : gt_ff;
      hi_y = (ab_ff < gb_ff) ? ab_ff : gb_ff;
      sgx  = {1'b0, gl_ff} + {1'b0, gr_ff};
      sax  = {1'b0, al_ff} + {1'b0, ar_ff};
      sgy  = {1'b0, gt_ff} + {1'b0, gb_ff};
      say  = {1'b0, at_ff} + {1'b0, ab_ff};
      twice_abs = acc_ff[TW] ? TW'(~acc_ff + 1'b1) : acc_ff[TW-1:0];
   end

   logic [2*MW-1:0] uni;
   logic [TW-1:0]   tdiff;
   assign uni   = p_a0_ff + p_a1_ff - p_inter_ff;
   assign tdiff = (gtwice_ff > atwice_ff) ? gtwice_ff - atwice_ff : atwice_ff - gtwice_ff;

   // order checks and decision terms
   logic        time_err, seq_err;
   logic [15:0] obs_next;
   logic        stable;

   always_comb begin
      time_err = lsv_ff && (tm_ff < ltime_ff);
      seq_err  = lsv_ff && (seq_ff < lseq_ff) && ((lseq_ff - seq_ff) < DST_SEQ_HALF);
      obs_next = (obs_ff == 16'hFFFF) ? obs_ff : obs_ff + 16'd1;
      stable   = (iou_q_ff >= min_iou_ff) &&
                 (shift_q_ff <= SH_W'(max_shift_ff)) &&
                 (atwice_ff != '0) &&
                 (area_q_ff <= {1'b0, max_area_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_obs_ff   <= RST_MIN_OBS;
         min_span_ff  <= RST_MIN_SPAN;
         min_iou_ff   <= RST_MIN_IOU;
         max_shift_ff <= RST_MAX_SHIFT;
         max_area_ff  <= RST_MAX_AREA;
         removal_ff   <= RST_REMOVAL_SPAN;
         fw_ff        <= RST_FRAME_WIDTH;
         fh_ff        <= RST_FRAME_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_MIN_OBS:      min_obs_ff   <= csr_wdata[15:0];
            CFG_MIN_SPAN:     min_span_ff  <= csr_wdata;
            CFG_MIN_IOU:      min_iou_ff   <= csr_wdata[16:0];
            CFG_MAX_SHIFT:    max_shift_ff <= csr_wdata[17:0];
            CFG_MAX_AREA:     max_area_ff  <= csr_wdata[31:0];
            CFG_REMOVAL_SPAN: removal_ff   <= csr_wdata;
            CFG_FRAME_WIDTH:  fw_ff        <= csr_wdata[11:0];
            CFG_FRAME_HEIGHT: fh_ff        <= csr_wdata[11:0];
            default:          fw_ff        <= fw_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_ABSENT;
         al_ff        <= '0;
         at_ff        <= '0;
         ar_ff        <= '0;
         ab_ff        <= '0;
         atwice_ff    <= '0;
         avalid_ff    <= 1'b0;
         lsv_ff       <= 1'b0;
         lseq_ff      <= '0;
         ltime_ff     <= '0;
         tstart_ff    <= '0;
         mstart_ff    <= '0;
         mflag_ff     <= 1'b0;
         obs_ff       <= '0;
         iou_ff       <= '0;
         shift_ff     <= '0;
         area_ff      <= '0;
         reason_ff    <= RSN_WAIT_REMOVAL;
         trig_ff      <= 1'b0;
         rearm_ff     <= 1'b0;
         div_start_ff <= 1'b0;
         sq_start_ff  <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         sq_start_ff  <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= req_tuser;
                  seq_ff   <= req_tdata[31:0];
                  tm_ff    <= req_tdata[95:32];
                  for (int i = 0; i < N; i++) begin
                     cx_ff[i] <= req_tdata[96 + 2*i*CB +: CB];
                     cy_ff[i] <= req_tdata[96 + (2*i+1)*CB +: CB];
                  end
                  trig_ff  <= 1'b0;
                  rearm_ff <= 1'b0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               priority if (time_err) begin
                  reason_ff <= RSN_TIME_ORDER;
                  state_ff  <= S_OUT;
               end else if (seq_err) begin
                  reason_ff <= RSN_SEQ_ORDER;
                  state_ff  <= S_OUT;
               end else if (op_ff) begin
                  state_ff <= S_OUT;
                  if (mode_ff == MODE_LOCKED && !mflag_ff) begin
                     mflag_ff  <= 1'b1;
                     mstart_ff <= tm_ff;
                     reason_ff <= RSN_REMOVAL_PEND;
                  end else if (mode_ff == MODE_LOCKED && (tm_ff - mstart_ff) < removal_ff) begin
                     reason_ff <= RSN_REMOVAL_PEND;
                  end else begin
                     rearm_ff  <= (mode_ff == MODE_LOCKED);
                     reason_ff <= (mode_ff == MODE_LOCKED) ? RSN_REMOVED : RSN_NOT_DETECTED;
                     mode_ff   <= MODE_ABSENT;
                     al_ff     <= '0;
                     at_ff     <= '0;
                     ar_ff     <= '0;
                     ab_ff     <= '0;
                     atwice_ff <= '0;
                     avalid_ff <= 1'b0;
                     lsv_ff    <= 1'b1;
                     lseq_ff   <= seq_ff;
                     ltime_ff  <= tm_ff;
                     tstart_ff <= '0;
                     mstart_ff <= '0;
                     mflag_ff  <= 1'b0;
                     obs_ff    <= '0;
                     iou_ff    <= '0;
                     shift_ff  <= '0;
                     area_ff   <= '0;
                  end
               end else begin
                  mflag_ff <= 1'b0;
                  if (mode_ff == MODE_LOCKED) begin
                     reason_ff <= RSN_WAIT_REMOVAL;
                     state_ff  <= S_OUT;
                  end else if (avalid_ff && lsv_ff && seq_ff == lseq_ff) begin
                     reason_ff <= RSN_DUPLICATE;
                     state_ff  <= S_OUT;
                  end else begin
                     gl_ff    <= bl;
                     gt_ff    <= bt;
                     gr_ff    <= br;
                     gb_ff    <= bb;
                     acc_ff   <= '0;
                     aidx_ff  <= '0;
                     state_ff <= S_AM;
                  end
               end
            end
            S_AM: begin
               prod_ff  <= mul_p;
               state_ff <= S_AA1;
            end
            S_AA1: begin
               acc_ff   <= acc_ff + (TW+1)'(prod_ff);
               prod_ff  <= mul_p;
               state_ff <= S_AA2;
            end
            S_AA2: begin
               acc_ff <= acc_ff - (TW+1)'(prod_ff);
               for (int i = 0; i < N; i++) begin
                  cx_ff[i] <= cx_ff[(i + 1) % N];
                  cy_ff[i] <= cy_ff[(i + 1) % N];
               end
               if (aidx_ff == IDXW'(N - 1)) begin
                  state_ff <= S_ANCH;
               end else begin
                  aidx_ff  <= aidx_ff + 1'b1;
                  state_ff <= S_AM;
               end
            end
            S_ANCH: begin
               gtwice_ff <= twice_abs;
               if (!avalid_ff) begin
                  reason_ff <= RSN_ACQUIRED;
                  state_ff  <= S_START;
               end else begin
                  state_ff <= S_GEO;
               end
            end
            S_GEO: begin
               iw_ff  <= (hi_x > lo_x) ? MW'(hi_x - lo_x) : '0;
               ih_ff  <= (hi_y > lo_y) ? MW'(hi_y - lo_y) : '0;
               a0w_ff <= (ar_ff > al_ff) ? MW'(ar_ff - al_ff) : '0;
               a0h_ff <= (ab_ff > at_ff) ? MW'(ab_ff - at_ff) : '0;
               a1w_ff <= (gr_ff > gl_ff) ? MW'(gr_ff - gl_ff) : '0;
               a1h_ff <= (gb_ff > gt_ff) ? MW'(gb_ff - gt_ff) : '0;
               dx_ff  <= (sgx > sax) ? MW'(sgx - sax) : MW'(sax - sgx);
               dy_ff  <= (sgy > say) ? MW'(sgy - say) : MW'(say - sgy);
               midx_ff  <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               unique case (midx_ff)
                  3'd0:    p_inter_ff <= mul_p;
                  3'd1:    p_a0_ff    <= mul_p;
                  3'd2:    p_a1_ff    <= mul_p;
                  3'd3:    p_dx2_ff   <= mul_p;
                  3'd4:    p_dy2_ff   <= mul_p;
                  3'd5:    p_w2_ff    <= mul_p;
                  default: p_h2_ff    <= mul_p;
               endcase
               if (midx_ff == 3'd6) begin
                  dsel_ff  <= '0;
                  state_ff <= S_DSTART;
               end else begin
                  midx_ff <= midx_ff + 3'd1;
               end
            end
            S_DSTART: begin
               unique case (dsel_ff)
                  2'd0: begin
                     div_num_ff <= NW'(p_inter_ff) << 16;
                     div_den_ff <= DW'(uni);
                  end
                  2'd1: begin
                     div_num_ff <= NW'(p_dx2_ff) << 22;
                     div_den_ff <= DW'(p_w2_ff);
                  end
                  2'd2: begin
                     div_num_ff <= NW'(p_dy2_ff) << 22;
                     div_den_ff <= DW'(p_h2_ff);
                  end
                  default: begin
                     div_num_ff <= NW'(tdiff) << 16;
                     div_den_ff <= DW'(atwice_ff);
                  end
               endcase
               div_start_ff <= 1'b1;
               state_ff     <= S_DWAIT;
            end
            S_DWAIT: begin
               if (div_done) begin
                  unique case (dsel_ff)
                     2'd0: iou_q_ff <= (uni == '0) ? 17'd0 : div_quot[16:0];
                     2'd1: sx_ff    <= (SQ_W-1)'(div_quot);
                     2'd2: sy_ff    <= (SQ_W-1)'(div_quot);
                     default: begin
                        if (atwice_ff == '0 || (|div_quot[NW-1:32]))
                           area_q_ff <= 33'h1_0000_0000;
                        else
                           area_q_ff <= {1'b0, div_quot[31:0]};
                     end
                  endcase
                  if (dsel_ff == 2'd3) begin
                     state_ff <= S_SQSTART;
                  end else begin
                     dsel_ff  <= dsel_ff + 2'd1;
                     state_ff <= S_DSTART;
                  end
               end
            end
            S_SQSTART: begin
               sq_start_ff <= 1'b1;
               state_ff    <= S_SQWAIT;
            end
            S_SQWAIT: begin
               if (sq_done) begin
                  shift_q_ff <= sq_root;
                  state_ff   <= S_DEC;
               end
            end
            S_DEC: begin
               iou_ff   <= iou_q_ff;
               shift_ff <= (|shift_q_ff[SH_W-1:18]) ? 18'h3FFFF : shift_q_ff[17:0];
               area_ff  <= area_q_ff[32] ? 32'hFFFF_FFFF : area_q_ff[31:0];
               if (!stable) begin
                  reason_ff <= RSN_MOVED;
                  state_ff  <= S_START;
               end else begin
                  lseq_ff  <= seq_ff;
                  ltime_ff <= tm_ff;
                  obs_ff   <= obs_next;
                  state_ff <= S_OUT;
                  if (obs_next >= min_obs_ff && (tm_ff - tstart_ff) >= min_span_ff) begin
                     mode_ff   <= MODE_LOCKED;
                     trig_ff   <= 1'b1;
                     reason_ff <= RSN_STABLE;
                  end else begin
                     reason_ff <= (obs_next >= 16'd2) ? RSN_PRESTABLE : RSN_PENDING;
                  end
               end
            end
            S_START: begin
               mode_ff   <= MODE_TRACK;
               al_ff     <= gl_ff;
               at_ff     <= gt_ff;
               ar_ff     <= gr_ff;
               ab_ff     <= gb_ff;
               atwice_ff <= gtwice_ff;
               avalid_ff <= 1'b1;
               lsv_ff    <= 1'b1;
               lseq_ff   <= seq_ff;
               ltime_ff  <= tm_ff;
               tstart_ff <= tm_ff;
               obs_ff    <= 16'd1;
               iou_ff    <= 17'h10000;
               shift_ff  <= '0;
               area_ff   <= '0;
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               if (rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   logic        prestable;
   logic [63:0] span;
   assign prestable = (mode_ff == MODE_TRACK) && (obs_ff >= 16'd2);
   assign span      = (avalid_ff && ltime_ff >= tstart_ff) ? ltime_ff - tstart_ff : 64'd0;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {4'b0000, rearm_ff, trig_ff, area_ff, shift_ff, iou_ff, span,
                        obs_ff, prestable, reason_ff, mode_ff};

endmodule
`default_nettype wire
